// ===== rtl/core/pose_local_offset_macros.svh =====
// assertion macros for the pose local offset block
// expects clk and rst_n in the scope of each use
`ifndef POSE_LOCAL_OFFSET_MACROS_SVH
`define POSE_LOCAL_OFFSET_MACROS_SVH

// same-cycle implication
`define PLO_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// next-cycle implication
`define PLO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ===== rtl/core/plo_pkg.sv =====
// shared widths, control struct and divider step for the pose local offset block
// no dependencies
`default_nettype none

package plo_pkg;

    localparam int COORD_W         = 32;
    localparam int QUAT_W          = 16;
    localparam int PROD_W          = 32;
    localparam int N_W             = 33;
    localparam int R_W             = 34;
    localparam int ACC_W           = 66;
    localparam int Q_W             = 34;
    localparam int REM_W           = N_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = Q_W / STEPS_PER_STAGE;

    typedef struct packed {
        logic valid;
        logic zero;
    } plo_ctl_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [Q_W-1:0]   dq;
    } plo_div_t;

    // one restoring step: dividend bits shift out of the top of dq, quotient bits in at the bottom
    function automatic plo_div_t div_step(input plo_div_t cur, input logic [N_W-1:0] n);
        logic [REM_W:0] t;
        logic           qbit;
        plo_div_t       nxt;
        t    = {cur.rem, cur.dq[Q_W-1]};
        qbit = (t >= {1'b0, n});
        if (qbit)
        begin
            nxt.rem = REM_W'(t - {1'b0, n});
        end
        else
        begin
            nxt.rem = t[REM_W-1:0];
        end
        nxt.dq = {cur.dq[Q_W-2:0], qbit};
        return nxt;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/plo_rot.sv =====
// rotation front end: quaternion products, scaled rotation matrix, norm and matrix product
// depends on plo_pkg
`default_nettype none

module plo_rot
    import plo_pkg::*;
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic [2:0][COORD_W-1:0]       pos,
    input  wire logic [3:0][QUAT_W-1:0]        quat,    // x, y, z, w from index 0 up
    input  wire logic [2:0][COORD_W-1:0]       off,
    output plo_ctl_t                           ctl,
    output logic      [2:0][ACC_W-1:0]         acc,
    output logic      [N_W-1:0]                n,
    output logic      [2:0][COORD_W-1:0]       pos_out
);

    // stage 1: input capture
    logic                        v1_reg;
    logic [2:0][COORD_W-1:0]     pos1_reg;
    logic [2:0][COORD_W-1:0]     off1_reg;
    logic [3:0][QUAT_W-1:0]      q1_reg;
    // stage 2: component products xx yy zz ww xy xz yz wx wy wz
    logic                        v2_reg;
    logic [2:0][COORD_W-1:0]     pos2_reg;
    logic [2:0][COORD_W-1:0]     off2_reg;
    logic [9:0][PROD_W-1:0]      p2_reg;
    logic [9:0][PROD_W-1:0]      p2_next;
    // stage 3: scaled matrix and squared norm
    logic                        v3_reg;
    logic                        z3_reg;
    logic [2:0][COORD_W-1:0]     pos3_reg;
    logic [2:0][COORD_W-1:0]     off3_reg;
    logic [8:0][R_W-1:0]         r3_reg;
    logic [8:0][R_W-1:0]         r3_next;
    logic [N_W-1:0]              n3_reg;
    logic [N_W-1:0]              n3_next;
    // stage 4: matrix entry times offset
    logic                        v4_reg;
    logic                        z4_reg;
    logic [2:0][COORD_W-1:0]     pos4_reg;
    logic [N_W-1:0]              n4_reg;
    logic [8:0][ACC_W-1:0]       m4_reg;
    logic [8:0][ACC_W-1:0]       m4_next;
    // stage 5: row sums
    logic                        v5_reg;
    logic                        z5_reg;
    logic [2:0][COORD_W-1:0]     pos5_reg;
    logic [N_W-1:0]              n5_reg;
    logic [2:0][ACC_W-1:0]       a5_reg;
    logic [2:0][ACC_W-1:0]       a5_next;

    logic signed [QUAT_W-1:0] qx, qy, qz, qw;
    logic signed [R_W-1:0]    exx, eyy, ezz, eww, exy, exz, eyz, ewx, ewy, ewz;

    always_comb
    begin
        qx = $signed(q1_reg[0]);
        qy = $signed(q1_reg[1]);
        qz = $signed(q1_reg[2]);
        qw = $signed(q1_reg[3]);
        p2_next[0] = PROD_W'(qx * qx);
        p2_next[1] = PROD_W'(qy * qy);
        p2_next[2] = PROD_W'(qz * qz);
        p2_next[3] = PROD_W'(qw * qw);
        p2_next[4] = PROD_W'(qx * qy);
        p2_next[5] = PROD_W'(qx * qz);
        p2_next[6] = PROD_W'(qy * qz);
        p2_next[7] = PROD_W'(qw * qx);
        p2_next[8] = PROD_W'(qw * qy);
        p2_next[9] = PROD_W'(qw * qz);
    end

    always_comb
    begin
        exx = R_W'($signed(p2_reg[0]));
        eyy = R_W'($signed(p2_reg[1]));
        ezz = R_W'($signed(p2_reg[2]));
        eww = R_W'($signed(p2_reg[3]));
        exy = R_W'($signed(p2_reg[4]));
        exz = R_W'($signed(p2_reg[5]));
        eyz = R_W'($signed(p2_reg[6]));
        ewx = R_W'($signed(p2_reg[7]));
        ewy = R_W'($signed(p2_reg[8]));
        ewz = R_W'($signed(p2_reg[9]));
        // squares are never negative, so zero extension is exact
        n3_next = {1'b0, p2_reg[0]} + {1'b0, p2_reg[1]} + {1'b0, p2_reg[2]} + {1'b0, p2_reg[3]};
        r3_next[0] = R_W'(eww + exx - eyy - ezz);
        r3_next[1] = R_W'((exy - ewz) <<< 1);
        r3_next[2] = R_W'((exz + ewy) <<< 1);
        r3_next[3] = R_W'((exy + ewz) <<< 1);
        r3_next[4] = R_W'(eww - exx + eyy - ezz);
        r3_next[5] = R_W'((eyz - ewx) <<< 1);
        r3_next[6] = R_W'((exz - ewy) <<< 1);
        r3_next[7] = R_W'((eyz + ewx) <<< 1);
        r3_next[8] = R_W'(eww - exx - eyy + ezz);
    end

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m4_next[k] = ACC_W'($signed(r3_reg[k]) * $signed(off3_reg[k % 3]));
        end
        for (int i = 0; i < 3; i++)
        begin
            a5_next[i] = ACC_W'($signed(m4_reg[3*i]) + $signed(m4_reg[3*i+1])
                                + $signed(m4_reg[3*i+2]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos1_reg <= pos;
            off1_reg <= off;
            q1_reg   <= quat;
            pos2_reg <= pos1_reg;
            off2_reg <= off1_reg;
            p2_reg   <= p2_next;
            pos3_reg <= pos2_reg;
            off3_reg <= off2_reg;
            r3_reg   <= r3_next;
            n3_reg   <= n3_next;
            z3_reg   <= (n3_next == '0);
            pos4_reg <= pos3_reg;
            n4_reg   <= n3_reg;
            z4_reg   <= z3_reg;
            m4_reg   <= m4_next;
            pos5_reg <= pos4_reg;
            n5_reg   <= n4_reg;
            z5_reg   <= z4_reg;
            a5_reg   <= a5_next;
        end
    end

    assign ctl.valid = v5_reg;
    assign ctl.zero  = z5_reg;
    assign acc       = a5_reg;
    assign n         = n5_reg;
    assign pos_out   = pos5_reg;

endmodule

`default_nettype wire

// ===== rtl/core/plo_div.sv =====
// one coordinate lane: pipelined rounding divide by the squared norm, add and clip
// depends on plo_pkg
`default_nettype none

module plo_div
    import plo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire plo_ctl_t             ctl_in,
    input  wire logic [ACC_W-1:0]     acc,
    input  wire logic [N_W-1:0]       n,
    input  wire logic [COORD_W-1:0]   pos,
    output plo_ctl_t                  ctl_out,
    output logic      [COORD_W-1:0]   res,
    output logic                      sat
);

    // index 0 is the magnitude stage, DIV_STAGES the last divide stage
    plo_ctl_t            ctl_reg [DIV_STAGES+1];
    plo_div_t            dv_reg  [DIV_STAGES+1];
    plo_div_t            dv_next [DIV_STAGES+1];
    logic [N_W-1:0]      n_reg   [DIV_STAGES+1];
    logic [COORD_W-1:0]  pos_reg [DIV_STAGES+1];
    logic                neg_reg [DIV_STAGES+1];

    logic [ACC_W-1:0]    mag;

    // rounding and sign stages
    plo_ctl_t            cf1_reg, cf2_reg, cf3_reg;
    logic                up_reg;
    logic [Q_W-1:0]      q_reg;
    logic                negf1_reg;
    logic [COORD_W-1:0]  posf1_reg, posf2_reg;
    logic [Q_W+1:0]      sq_reg;
    logic [Q_W+1:0]      sq_next;
    logic [COORD_W-1:0]  res_reg, res_next;
    logic                sat_reg, sat_next;
    logic [COORD_W+4:0]  total;

    always_comb
    begin
        mag        = acc[ACC_W-1] ? ACC_W'(-acc) : acc;
        // the rotated vector is no longer than the offset, so the top part starts below n
        dv_next[0] = '{rem: REM_W'(mag[ACC_W-1:Q_W]), dq: mag[Q_W-1:0]};
        for (int s = 1; s <= DIV_STAGES; s++)
        begin
            dv_next[s] = dv_reg[s-1];
            for (int k = 0; k < STEPS_PER_STAGE; k++)
            begin
                dv_next[s] = div_step(dv_next[s], n_reg[s-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= DIV_STAGES; s++)
            begin
                ctl_reg[s] <= '0;
            end
            cf1_reg <= '0;
            cf2_reg <= '0;
            cf3_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg[0] <= ctl_in;
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                ctl_reg[s] <= ctl_reg[s-1];
            end
            cf1_reg <= ctl_reg[DIV_STAGES];
            cf2_reg <= cf1_reg;
            cf3_reg <= cf2_reg;
        end
    end

    always_comb
    begin
        sq_next = negf1_reg ? (Q_W+2)'(-({2'b00, q_reg} + (Q_W+2)'(up_reg)))
                            : ({2'b00, q_reg} + (Q_W+2)'(up_reg));
        total   = (COORD_W+5)'($signed(posf2_reg)) + (COORD_W+5)'($signed(sq_reg));
        sat_next = 1'b0;
        if (cf2_reg.zero)
        begin
            res_next = posf2_reg;
        end
        else if ($signed(total) > $signed({6'b000000, {(COORD_W-1){1'b1}}}))
        begin
            res_next = {1'b0, {(COORD_W-1){1'b1}}};
            sat_next = 1'b1;
        end
        else if ($signed(total) < $signed({6'b111111, {(COORD_W-1){1'b0}}}))
        begin
            res_next = {1'b1, {(COORD_W-1){1'b0}}};
            sat_next = 1'b1;
        end
        else
        begin
            res_next = total[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0]  <= dv_next[0];
            n_reg[0]   <= n;
            pos_reg[0] <= pos;
            neg_reg[0] <= acc[ACC_W-1];
            for (int s = 1; s <= DIV_STAGES; s++)
            begin
                dv_reg[s]  <= dv_next[s];
                n_reg[s]   <= n_reg[s-1];
                pos_reg[s] <= pos_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
            // round half away from zero on the magnitude
            up_reg    <= (dv_reg[DIV_STAGES].rem >= n_reg[DIV_STAGES] - dv_reg[DIV_STAGES].rem);
            q_reg     <= dv_reg[DIV_STAGES].dq;
            negf1_reg <= neg_reg[DIV_STAGES];
            posf1_reg <= pos_reg[DIV_STAGES];
            sq_reg    <= sq_next;
            posf2_reg <= posf1_reg;
            res_reg   <= res_next;
            sat_reg   <= sat_next;
        end
    end

    assign ctl_out = cf3_reg;
    assign res     = res_reg;
    assign sat     = sat_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pose_local_offset.sv =====
// throughput: one word per cycle while s_tready is high; the 17-stage divider (two quotient bits a stage) sets depth
// a two-entry output buffer keeps s_tready registered; a stall freezes the whole pipeline
// reset (rst_n low, asynchronous) clears all valid bits; data registers are not reset
// depends on plo_pkg, plo_rot, plo_div and pose_local_offset_macros.svh
`default_nettype none
`include "pose_local_offset_macros.svh"

module pose_local_offset
    import plo_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [255:0] s_tdata,   // pos_x, pos_y, pos_z, quat_x, quat_y, quat_z, quat_w,
                                         // off_x, off_y, off_z
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // new_x, new_y, new_z
    output logic [1:0]        m_tuser    // zero_quat, saturated
);

    logic                      en;
    plo_ctl_t                  rot_ctl;
    logic [2:0][ACC_W-1:0]     rot_acc;
    logic [N_W-1:0]            rot_n;
    logic [2:0][COORD_W-1:0]   rot_pos;
    plo_ctl_t                  lane_ctl [3];
    logic [2:0][COORD_W-1:0]   lane_res;
    logic [2:0]                lane_sat;

    logic                      push;
    logic                      take;
    logic                      out_valid_reg;
    logic [95:0]               out_data_reg;
    logic [1:0]                out_user_reg;
    logic                      skid_valid_reg;
    logic [95:0]               skid_data_reg;
    logic [1:0]                skid_user_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    plo_rot u_rot (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .pos      (s_tdata[95:0]),
        .quat     (s_tdata[159:96]),
        .off      (s_tdata[255:160]),
        .ctl      (rot_ctl),
        .acc      (rot_acc),
        .n        (rot_n),
        .pos_out  (rot_pos)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_lane
        plo_div u_div (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (rot_ctl),
            .acc     (rot_acc[g]),
            .n       (rot_n),
            .pos     (rot_pos[g]),
            .ctl_out (lane_ctl[g]),
            .res     (lane_res[g]),
            .sat     (lane_sat[g])
        );
    end

    assign push = en && lane_ctl[0].valid;
    assign take = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else
            begin
                out_data_reg <= lane_res;
                out_user_reg <= {|lane_sat, lane_ctl[0].zero};
            end
        end
        else if (push)
        begin
            skid_data_reg <= lane_res;
            skid_user_reg <= {|lane_sat, lane_ctl[0].zero};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // a passed-through position is never reported as clipped
    `PLO_ASSERT_NOW(a_zero_not_sat, out_valid_reg && out_user_reg[0], !out_user_reg[1])
    // the skid entry is only used behind a waiting output word
    `PLO_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // a word held in the skid entry is not dropped while the sink stalls
    `PLO_ASSERT_NEXT(a_skid_holds, skid_valid_reg && !m_tready, skid_valid_reg)
    // all three lanes stay in step
    `PLO_ASSERT_NOW(a_lanes_aligned, 1'b1,
        (lane_ctl[0].valid == lane_ctl[1].valid) && (lane_ctl[0].valid == lane_ctl[2].valid))

endmodule

`default_nettype wire

// ===== tb/pose_local_offset_check.sv =====
// checker for pose_local_offset: predicts each result from the accepted slave words
// and compares them in order with the master words; depends on the dut port layout only
`timescale 1ns / 100ps

module pose_local_offset_check
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [255:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [95:0]  m_tdata,
    input  logic [1:0]   m_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct packed {
        logic [31:0] nz;
        logic [31:0] ny;
        logic [31:0] nx;
        logic        saturated;
        logic        zero_quat;
    } pose_res_t;

    pose_res_t expected_poses[$];
    int        mismatches;

    // round to nearest, ties away from zero
    function automatic logic signed [127:0] div_round(logic signed [127:0] num, longint n);
        logic [127:0] mag;
        logic [127:0] q;
        logic [127:0] rem;
        mag = (num < 0) ? -num : num;
        q   = mag / n;
        rem = mag % n;
        if (rem >= n - rem)
        begin
            q = q + 1;
        end
        q = q & ((128'd1 << 40) - 1);
        return (num < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic pose_res_t move_pose(logic [255:0] d);
        longint             p[3];
        longint             o[3];
        longint             r[3][3];
        longint             x, y, z, w, n;
        logic signed [127:0] acc, sum;
        logic [31:0]        c[3];
        pose_res_t          res;
        for (int i = 0; i < 3; i++)
        begin
            p[i] = longint'($signed(d[32*i +: 32]));
            o[i] = longint'($signed(d[160 + 32*i +: 32]));
        end
        x = longint'($signed(d[111:96]));
        y = longint'($signed(d[127:112]));
        z = longint'($signed(d[143:128]));
        w = longint'($signed(d[159:144]));
        n = x*x + y*y + z*z + w*w;
        res = '0;
        if (n == 0)
        begin
            res.nx = d[31:0];
            res.ny = d[63:32];
            res.nz = d[95:64];
            res.zero_quat = 1'b1;
            return res;
        end
        r[0][0] = w*w + x*x - y*y - z*z;
        r[0][1] = 2*(x*y - w*z);
        r[0][2] = 2*(x*z + w*y);
        r[1][0] = 2*(x*y + w*z);
        r[1][1] = w*w - x*x + y*y - z*z;
        r[1][2] = 2*(y*z - w*x);
        r[2][0] = 2*(x*z - w*y);
        r[2][1] = 2*(y*z + w*x);
        r[2][2] = w*w - x*x - y*y + z*z;
        for (int i = 0; i < 3; i++)
        begin
            acc = 128'sd0;
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + 128'(r[i][j]) * 128'(o[j]);
            end
            sum = 128'(p[i]) + div_round(acc, n);
            if (sum > 128'sd2147483647)
            begin
                sum = 128'sd2147483647;
                res.saturated = 1'b1;
            end
            if (sum < -128'sd2147483648)
            begin
                sum = -128'sd2147483648;
                res.saturated = 1'b1;
            end
            c[i] = sum[31:0];
        end
        res.nx = c[0];
        res.ny = c[1];
        res.nz = c[2];
        return res;
    endfunction

    assign pending = expected_poses.size();

    always @(posedge clk or negedge rst_n)
    begin
        pose_res_t want, got;
        if (!rst_n)
        begin
            fail_count <= 0;
            mismatches = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_poses.push_back(move_pose(s_tdata));
            end
            if (m_tvalid && m_tready)
            begin
                got = {m_tdata[95:64], m_tdata[63:32], m_tdata[31:0], m_tuser[1], m_tuser[0]};
                if (expected_poses.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected result word %h", got);
                    end
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: x %h/%h y %h/%h z %h/%h zero %b/%b sat %b/%b",
                                     want.nx, got.nx, want.ny, got.ny, want.nz, got.nz,
                                     want.zero_quat, got.zero_quat,
                                     want.saturated, got.saturated);
                        end
                    end
                end
                fail_count <= mismatches;
            end
        end
    end

endmodule

// ===== tb/pose_local_offset_test.sv =====
// top of the pose_local_offset testbench: clock, reset, directed and random poses,
// output back-pressure and verdict; depends on pose_local_offset and pose_local_offset_check
`timescale 1ns / 100ps

module pose_local_offset_test;

    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_TAIL   = 200;
    localparam int IDLE_LIMIT   = 2000;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending;
    logic         quiet;
    int           ready_left = 0;
    int           idle_cycles = 0;

    pose_local_offset dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    pose_local_offset_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [255:0] pack_pose(logic [31:0] px, logic [31:0] py,
                                               logic [31:0] pz, logic [15:0] qx,
                                               logic [15:0] qy, logic [15:0] qz,
                                               logic [15:0] qw, logic [31:0] ox,
                                               logic [31:0] oy, logic [31:0] oz);
        return {oz, oy, ox, qw, qz, qy, qx, pz, py, px};
    endfunction

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($signed($urandom_range(0, 4095)) - 2048);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_quat();
        case ($urandom_range(0, 7))
            0: return 16'h7fff;
            1: return 16'h8000;
            2: return 16'h4000;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [255:0] random_pose();
        logic [15:0] q[4];
        int          k;
        for (int i = 0; i < 4; i++)
        begin
            q[i] = 16'($urandom);
        end
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            q = '{16'h0, 16'h0, 16'h0, 16'h0};
        end
        else if (k < 4)
        begin
            for (int i = 0; i < 4; i++)
            begin
                q[i] = pick_quat();
            end
        end
        return pack_pose(pick_coord(), pick_coord(), pick_coord(), q[0], q[1], q[2], q[3],
                         pick_coord(), pick_coord(), pick_coord());
    endfunction

    task automatic send_pose(logic [255:0] d, bit allow_gap);
        if (allow_gap && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
    endtask

    // output back-pressure in bursts
    always @(posedge clk)
    begin
        if (quiet)
        begin
            m_tready <= 1'b1;
        end
        else if (ready_left > 0)
        begin
            ready_left <= ready_left - 1;
        end
        else
        begin
            m_tready   <= ($urandom_range(0, 2) != 0);
            ready_left <= $urandom_range(1, 9);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        quiet       = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero quaternion, identity, extremes of every field, half turns
        send_pose(pack_pose(32'h12345678, 32'h80000000, 32'h7fffffff, 16'h0, 16'h0, 16'h0,
                            16'h0, 32'h7fffffff, 32'h80000000, 32'h1), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h4000,
                            32'h00010000, 32'hffff0000, 32'h00020000), 1'b0);
        send_pose(pack_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16'h0, 16'h0, 16'h0,
                            16'h4000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0);
        send_pose(pack_pose(32'h80000000, 32'h80000000, 32'h80000000, 16'h0, 16'h0, 16'h0,
                            16'h4000, 32'h80000000, 32'h80000000, 32'h80000000), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                            32'h80000000, 32'h80000000, 32'h80000000), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0);
        send_pose(pack_pose(32'h7fffffff, 32'h0, 32'h80000000, 16'h4000, 16'h0, 16'h0,
                            16'h0, 32'h1, 32'h1, 32'h1), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0, 16'h0,
                            32'h3, 32'h5, 32'hfffffffb), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h8000, 16'h0,
                            32'h7fffffff, 32'h80000000, 32'h0), 1'b0);
        // tiny quaternions make rounding ties likely
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h1, 16'h1, 16'h0, 16'h0,
                            32'h1, 32'h0, 32'h0), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h1, 16'h0, 16'h0, 16'h1,
                            32'h1, 32'hffffffff, 32'h3), 1'b0);
        send_pose(pack_pose(32'h5, 32'hfffffffb, 32'h0, 16'hffff, 16'h1, 16'h1, 16'h1,
                            32'h1, 32'h1, 32'hffffffff), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 16'h1,
                            32'h0, 32'h0, 32'h0), 1'b0);
        send_pose(pack_pose(32'h0, 32'h0, 32'h0, 16'h2d41, 16'h0, 16'h0, 16'h2d41,
                            32'h00010000, 32'h00010000, 32'h00010000), 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - QUIET_TAIL)
            begin
                quiet = 1'b1;
            end
            send_pose(random_pose(), !quiet);
        end
        s_tvalid <= 1'b0;
        quiet = 1'b1;

        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== pose_local_offset.f =====
+incdir+rtl/core
rtl/core/plo_pkg.sv
rtl/core/plo_rot.sv
rtl/core/plo_div.sv
rtl/core/pose_local_offset.sv
tb/pose_local_offset_check.sv
tb/pose_local_offset_test.sv
